// ===== src/ipd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the image packet deframer.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // field widths fixed by the packet format
    localparam int unsigned TALLY_W = 17;
    localparam int unsigned LEN_W   = 16;

    // result queue depth, a power of two
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header magic bytes
    localparam logic [7:0] MAGIC0 = 8'h4B;
    localparam logic [7:0] MAGIC1 = 8'h49;

    // tally after the header packet
    localparam logic [TALLY_W-1:0] HDR_TALLY = 17'd12;

    // byte positions inside the header packet
    localparam int unsigned POS_MAGIC0  = 0;
    localparam int unsigned POS_MAGIC1  = 1;
    localparam int unsigned POS_WIDTH   = 2;
    localparam int unsigned POS_HEIGHT  = 3;
    localparam int unsigned POS_LEN_HI  = 4;
    localparam int unsigned POS_LEN_LO  = 5;
    localparam int unsigned POS_CHECK   = 6;
    localparam int unsigned HDR_LAST_COLOUR = 18;

    // last colour byte inside a colour packet
    localparam int unsigned PKT_LAST_COLOUR = 17;

    // offset inside an rgb triple
    localparam logic [1:0] OFF_RED   = 2'd0;
    localparam logic [1:0] OFF_GREEN = 2'd1;
    localparam logic [1:0] OFF_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COLOUR1 = 3'd1,
        PH_COLOUR2 = 3'd2,
        PH_DATA    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_COLOUR = 2'd1,
        KIND_PIXEL  = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  img_wide;
        logic [7:0]  img_tall;
        logic [3:0]  colour_slot;
        logic [23:0] colour_rgb;
        logic [7:0]  pixel_byte;
        logic [7:0]  final_sum;
        logic        sum_ok;
        logic        last;
    } res_t;

    // results produced by one byte, in delivery order
    typedef struct packed {
        logic one;
        logic two;
        res_t res0;
        res_t res1;
    } push_t;

endpackage

// ===== src/ipd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_core
// Packet position counter, header capture, colour assembly, data checksum
// and length tally. Turns one accepted byte into zero, one or two results.
// ----------------------------------------------------------------------------
module ipd_core #(
    parameter int unsigned PACKET_BYTES = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output ipd_pkg::push_t push
);

    localparam int unsigned POS_W = $clog2(PACKET_BYTES);

    typedef logic [ipd_pkg::TALLY_W:0] wide_t;

    ipd_pkg::phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         magic_reg, magic_next;
    logic [7:0]                   width_reg, width_next;
    logic [7:0]                   height_reg, height_next;
    logic [ipd_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [7:0]                   expect_reg, expect_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [ipd_pkg::TALLY_W-1:0]  tally_reg, tally_next;
    logic [15:0]                  acc_reg, acc_next;
    logic [3:0]                   ccount_reg, ccount_next;
    logic [1:0]                   off_reg, off_next;

    logic                         pkt_end;
    logic                         col_byte;
    logic                         advance;
    logic                         col_hit, start_hit, pix_hit, done_hit;
    logic                         match;
    logic [ipd_pkg::TALLY_W-1:0]  tally_adv;
    wide_t                        tally_pos;
    ipd_pkg::res_t                col_res, start_res, pix_res, done_res;

    assign pkt_end   = (pos_reg == POS_W'(PACKET_BYTES - 1));
    assign tally_adv = tally_reg + ipd_pkg::TALLY_W'(PACKET_BYTES);
    assign tally_pos = wide_t'(tally_reg) + wide_t'(pos_reg) + wide_t'(1);
    assign match     = (sum_next == expect_reg);

    // per-byte state update
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        magic_next  = magic_reg;
        width_next  = width_reg;
        height_next = height_reg;
        len_next    = len_reg;
        expect_next = expect_reg;
        sum_next    = sum_reg;
        tally_next  = tally_reg;
        acc_next    = acc_reg;
        ccount_next = ccount_reg;
        off_next    = off_reg;
        col_byte    = 1'b0;
        advance     = 1'b0;
        start_hit   = 1'b0;
        pix_hit     = 1'b0;
        done_hit    = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                ipd_pkg::PH_HEADER:
                begin
                    advance = 1'b1;
                    priority if (pos_reg == POS_W'(ipd_pkg::POS_MAGIC0))
                    begin
                        magic_next  = (rx_byte == ipd_pkg::MAGIC0);
                        ccount_next = 4'd0;
                    end
                    else if (pos_reg == POS_W'(ipd_pkg::POS_MAGIC1))
                    begin
                        magic_next = magic_reg && (rx_byte == ipd_pkg::MAGIC1);
                    end
                    else if (magic_reg)
                    begin
                        priority if (pos_reg == POS_W'(ipd_pkg::POS_WIDTH))
                            width_next = rx_byte;
                        else if (pos_reg == POS_W'(ipd_pkg::POS_HEIGHT))
                            height_next = rx_byte;
                        else if (pos_reg == POS_W'(ipd_pkg::POS_LEN_HI))
                            len_next = {rx_byte, len_reg[7:0]};
                        else if (pos_reg == POS_W'(ipd_pkg::POS_LEN_LO))
                            len_next = {len_reg[15:8], rx_byte};
                        else if (pos_reg == POS_W'(ipd_pkg::POS_CHECK))
                            expect_next = rx_byte;
                        else if (pos_reg <= POS_W'(ipd_pkg::HDR_LAST_COLOUR))
                            col_byte = 1'b1;
                        else
                            col_byte = 1'b0;
                    end
                    else
                    begin
                        col_byte = 1'b0;
                    end
                    if (pkt_end && magic_reg)
                    begin
                        tally_next = ipd_pkg::HDR_TALLY;
                        phase_next = ipd_pkg::PH_COLOUR1;
                    end
                end
                ipd_pkg::PH_COLOUR1, ipd_pkg::PH_COLOUR2:
                begin
                    advance  = 1'b1;
                    col_byte = (pos_reg <= POS_W'(ipd_pkg::PKT_LAST_COLOUR));
                    if (pkt_end)
                    begin
                        tally_next = tally_adv;
                        if (phase_reg == ipd_pkg::PH_COLOUR2)
                        begin
                            start_hit  = 1'b1;
                            sum_next   = 8'd0;
                            phase_next = ipd_pkg::PH_DATA;
                        end
                        else
                        begin
                            phase_next = ipd_pkg::PH_COLOUR2;
                        end
                    end
                end
                ipd_pkg::PH_DATA:
                begin
                    advance  = 1'b1;
                    sum_next = sum_reg + rx_byte;
                    pix_hit  = (tally_pos <= wide_t'(len_reg));
                    if (pkt_end)
                    begin
                        tally_next = tally_adv;
                        if (tally_adv >= ipd_pkg::TALLY_W'(len_reg))
                        begin
                            done_hit   = 1'b1;
                            phase_next = match ? ipd_pkg::PH_DONE : ipd_pkg::PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    advance = 1'b0;
                end
            endcase

            // colour triple assembly
            if (col_byte)
            begin
                unique case (off_reg)
                    ipd_pkg::OFF_RED:   acc_next = {8'd0, rx_byte};
                    ipd_pkg::OFF_GREEN: acc_next = {acc_reg[7:0], rx_byte};
                    default:            ccount_next = ccount_next + 4'd1;
                endcase
                off_next = (off_reg == ipd_pkg::OFF_BLUE) ? ipd_pkg::OFF_RED
                                                          : off_reg + 2'd1;
            end

            // position within the packet
            if (advance)
            begin
                if (pkt_end)
                begin
                    pos_next = '0;
                    off_next = ipd_pkg::OFF_RED;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    assign col_hit = col_byte && (off_reg == ipd_pkg::OFF_BLUE);

    // candidate results
    always_comb
    begin
        col_res             = '0;
        col_res.kind        = ipd_pkg::KIND_COLOUR;
        col_res.colour_slot = ccount_reg;
        col_res.colour_rgb  = {acc_reg, rx_byte};
        col_res.last        = 1'b1;

        start_res           = '0;
        start_res.kind      = ipd_pkg::KIND_START;
        start_res.img_wide  = width_reg;
        start_res.img_tall  = height_reg;
        start_res.last      = 1'b1;

        pix_res             = '0;
        pix_res.kind        = ipd_pkg::KIND_PIXEL;
        pix_res.pixel_byte  = rx_byte;
        pix_res.last        = !done_hit;

        done_res            = '0;
        done_res.kind       = ipd_pkg::KIND_DONE;
        done_res.final_sum  = sum_next;
        done_res.sum_ok     = match;
        done_res.last       = 1'b1;
    end

    // result ordering: image byte before transfer done
    always_comb
    begin
        push.one  = col_hit || start_hit || pix_hit || done_hit;
        push.two  = pix_hit && done_hit;
        push.res1 = done_res;
        priority if (col_hit)
            push.res0 = col_res;
        else if (start_hit)
            push.res0 = start_res;
        else if (pix_hit)
            push.res0 = pix_res;
        else
            push.res0 = done_res;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ipd_pkg::PH_HEADER;
            pos_reg    <= '0;
            magic_reg  <= 1'b0;
            width_reg  <= 8'd0;
            height_reg <= 8'd0;
            len_reg    <= '0;
            expect_reg <= 8'd0;
            sum_reg    <= 8'd0;
            tally_reg  <= '0;
            acc_reg    <= 16'd0;
            ccount_reg <= 4'd0;
            off_reg    <= ipd_pkg::OFF_RED;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            magic_reg  <= magic_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            len_reg    <= len_next;
            expect_reg <= expect_next;
            sum_reg    <= sum_next;
            tally_reg  <= tally_next;
            acc_reg    <= acc_next;
            ccount_reg <= ccount_next;
            off_reg    <= off_next;
        end
    end

endmodule

// ===== src/ipd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_queue
// Small result queue: takes up to two results a cycle, gives one a cycle
// while head_ready is high. Reports room while at least two entries are free.
// ----------------------------------------------------------------------------
module ipd_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ipd_pkg::push_t               push,
    output logic                         room,
    output logic [ipd_pkg::QCNT_W-1:0]   level,
    output logic                         head_valid,
    input  logic                         head_ready,
    output ipd_pkg::res_t                head
);

    ipd_pkg::res_t                entries_reg [ipd_pkg::QUEUE_DEPTH];
    logic [ipd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ipd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ipd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic [ipd_pkg::QPTR_W-1:0]   wr_ptr_two;
    logic                         pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign room       = (count_reg <= ipd_pkg::QCNT_W'(ipd_pkg::QUEUE_DEPTH - 2));
    assign level      = count_reg;
    assign wr_ptr_two = wr_ptr_reg + ipd_pkg::QPTR_W'(1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ipd_pkg::QPTR_W'(push.one)
                                 + ipd_pkg::QPTR_W'(push.two);
        rd_ptr_next = rd_ptr_reg + ipd_pkg::QPTR_W'(pop);
        count_next  = count_reg + ipd_pkg::QCNT_W'(push.one)
                                + ipd_pkg::QCNT_W'(push.two)
                                - ipd_pkg::QCNT_W'(pop);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.one)
            entries_reg[wr_ptr_reg] <= push.res0;
        if (push.two)
            entries_reg[wr_ptr_two] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/image_packet_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_packet_deframer
// Splits a received byte stream into fixed-size packets: header, two colour
// packets, then image data with a running 8-bit checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while rx_ready is high. Its
// results are written into a four-entry result queue at the same edge, and
// the first of them reaches the result port behind any older results; the
// queue delivers one result per cycle while res_ready is high. A byte is
// taken while the queue has two free entries, so with the result side always
// ready the block runs at one byte per cycle; the only byte that causes two
// results (an image byte together with transfer done) adds one entry that
// drains in the next cycle without a result. After a transfer done with a
// matching checksum the block swallows all further bytes until reset.
module image_packet_deframer #(
    parameter int unsigned PACKET_BYTES = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  kind,
    output logic [7:0]  img_wide,
    output logic [7:0]  img_tall,
    output logic [3:0]  colour_slot,
    output logic [23:0] colour_rgb,
    output logic [7:0]  pixel_byte,
    output logic [7:0]  final_sum,
    output logic        sum_ok,
    output logic        last
);

    logic                         accept;
    ipd_pkg::push_t               push;
    ipd_pkg::res_t                head;
    logic [ipd_pkg::QCNT_W-1:0]   level;
    logic                         locked_done;

    assign accept = rx_valid && rx_ready;

    // packet decoding
    ipd_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .push    (push)
    );

    // result queue
    ipd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (rx_ready),
        .level      (level),
        .head_valid (res_valid),
        .head_ready (res_ready),
        .head       (head)
    );

    // result fields
    assign kind        = head.kind;
    assign img_wide    = head.img_wide;
    assign img_tall    = head.img_tall;
    assign colour_slot = head.colour_slot;
    assign colour_rgb  = head.colour_rgb;
    assign pixel_byte  = head.pixel_byte;
    assign final_sum   = head.final_sum;
    assign sum_ok      = head.sum_ok;
    assign last        = head.last;

    // a matching transfer done in this cycle
    assign locked_done = (push.two && push.res1.sum_ok)
                      || (push.one && !push.two
                          && push.res0.kind == ipd_pkg::KIND_DONE && push.res0.sum_ok);

    // checks
    a_two_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
        push.two |-> push.one && !push.res0.last)
        else $error("second result without a first one");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ipd_pkg::QCNT_W'(ipd_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_done_locks: assert property (@(posedge clk) disable iff (!rst_n)
        locked_done |=> !push.one)
        else $error("result after a matching transfer done");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.one |-> accept)
        else $error("result without an accepted byte");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image packet deframer. Image sequences, bad
// headers and trailing bytes are queued for a clocked driver; a predictor
// derives the deframed results of every accepted byte and a clocked monitor
// compares each delivered result with the oldest one due. Both sides of the
// block see random gaps, one long result-side hold and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PKT = 20;

    // content fill of an image sequence
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    // kinds of broken header packet
    localparam int BAD_SECOND = 0;
    localparam int BAD_FIRST  = 1;
    localparam int BAD_ANY    = 2;

    // tally when the first data packet begins
    localparam int DATA_TALLY = int'(ipd_pkg::HDR_TALLY) + 2 * PKT;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  img_wide;
    logic [7:0]  img_tall;
    logic [3:0]  colour_slot;
    logic [23:0] colour_rgb;
    logic [7:0]  pixel_byte;
    logic [7:0]  final_sum;
    logic        sum_ok;
    logic        last;

    // byte stream still to be offered, and deframed results still due
    logic [7:0]      rx_backlog[$];
    ipd_pkg::res_t   due_results[$];
    ipd_pkg::res_t   step_results[$];
    ipd_pkg::res_t   want;

    int          queued_cnt = 0;
    int          bytes_taken = 0;
    int          fail_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned calm_left = 0;
    logic        calm = 1'b0;
    logic        sink_hold = 1'b0;

    // deframer state as seen by the predictor
    ipd_pkg::phase_t                 ph = ipd_pkg::PH_HEADER;
    logic [5:0]                      pos_r = '0;
    logic                            magic = 1'b0;
    logic [7:0]                      wide_r = '0;
    logic [7:0]                      tall_r = '0;
    logic [ipd_pkg::LEN_W-1:0]       len_r = '0;
    logic [7:0]                      chk_r = '0;
    logic [7:0]                      sum_r = '0;
    logic [ipd_pkg::TALLY_W-1:0]     tally_r = '0;
    logic [15:0]                     rgb_acc = '0;
    logic [3:0]                      slot_cnt = '0;

    image_packet_deframer #(
        .PACKET_BYTES (PKT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .img_wide    (img_wide),
        .img_tall    (img_tall),
        .colour_slot (colour_slot),
        .colour_rgb  (colour_rgb),
        .pixel_byte  (pixel_byte),
        .final_sum   (final_sum),
        .sum_ok      (sum_ok),
        .last        (last)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic ipd_pkg::res_t mk_res(input ipd_pkg::kind_t k,
                                             input logic [7:0] w,
                                             input logic [7:0] h,
                                             input logic [3:0] slot,
                                             input logic [23:0] rgb,
                                             input logic [7:0] pix,
                                             input logic [7:0] fsum,
                                             input logic ok);
        ipd_pkg::res_t r;
        r.kind        = k;
        r.img_wide    = w;
        r.img_tall    = h;
        r.colour_slot = slot;
        r.colour_rgb  = rgb;
        r.pixel_byte  = pix;
        r.final_sum   = fsum;
        r.sum_ok      = ok;
        r.last        = 1'b0;
        return r;
    endfunction

    // one byte of an rgb triple
    task automatic take_colour(input logic [1:0] off, input logic [7:0] b);
        if (off == ipd_pkg::OFF_RED)
            rgb_acc = {8'h00, b};
        else if (off == ipd_pkg::OFF_GREEN)
            rgb_acc = {rgb_acc[7:0], b};
        else
        begin
            step_results.push_back(mk_res(ipd_pkg::KIND_COLOUR, '0, '0, slot_cnt,
                                          {rgb_acc, b}, '0, '0, 1'b0));
            slot_cnt = slot_cnt + 4'd1;
        end
    endtask

    // results caused by one accepted byte, appended to the due list
    task automatic deframe_byte(input logic [7:0] b);
        logic pkt_end;
        logic ok;
        ipd_pkg::res_t tail;
        step_results.delete();
        pkt_end = (int'(pos_r) >= PKT - 1);
        if (ph >= ipd_pkg::PH_DONE)
            return;
        unique case (ph)
            ipd_pkg::PH_HEADER:
            begin
                if (pos_r == ipd_pkg::POS_MAGIC0)
                begin
                    magic    = (b == ipd_pkg::MAGIC0);
                    slot_cnt = '0;
                end
                else if (pos_r == ipd_pkg::POS_MAGIC1)
                    magic = magic && (b == ipd_pkg::MAGIC1);
                else if (magic)
                begin
                    if (pos_r == ipd_pkg::POS_WIDTH)
                        wide_r = b;
                    else if (pos_r == ipd_pkg::POS_HEIGHT)
                        tall_r = b;
                    else if (pos_r == ipd_pkg::POS_LEN_HI)
                        len_r[15:8] = b;
                    else if (pos_r == ipd_pkg::POS_LEN_LO)
                        len_r[7:0] = b;
                    else if (pos_r == ipd_pkg::POS_CHECK)
                        chk_r = b;
                    else if (pos_r <= ipd_pkg::HDR_LAST_COLOUR)
                        take_colour(2'((int'(pos_r) - int'(ipd_pkg::POS_CHECK) - 1) % 3),
                                    b);
                end
                if (pkt_end && magic)
                begin
                    tally_r = ipd_pkg::HDR_TALLY;
                    ph      = ipd_pkg::PH_COLOUR1;
                end
            end
            ipd_pkg::PH_COLOUR1, ipd_pkg::PH_COLOUR2:
            begin
                if (pos_r <= ipd_pkg::PKT_LAST_COLOUR)
                    take_colour(2'(int'(pos_r) % 3), b);
                if (pkt_end)
                begin
                    tally_r = tally_r + ipd_pkg::TALLY_W'(PKT);
                    if (ph == ipd_pkg::PH_COLOUR2)
                    begin
                        step_results.push_back(mk_res(ipd_pkg::KIND_START, wide_r,
                                                      tall_r, '0, '0, '0, '0, 1'b0));
                        sum_r = '0;
                        ph    = ipd_pkg::PH_DATA;
                    end
                    else
                        ph = ipd_pkg::PH_COLOUR2;
                end
            end
            default:
            begin
                sum_r = sum_r + b;
                // bytes past the declared length are summed only
                if (int'(tally_r) + int'(pos_r) + 1 <= int'(len_r))
                    step_results.push_back(mk_res(ipd_pkg::KIND_PIXEL, '0, '0, '0,
                                                  '0, b, '0, 1'b0));
                if (pkt_end)
                begin
                    tally_r = tally_r + ipd_pkg::TALLY_W'(PKT);
                    if (tally_r >= ipd_pkg::TALLY_W'(len_r))
                    begin
                        ok = (sum_r == chk_r);
                        step_results.push_back(mk_res(ipd_pkg::KIND_DONE, '0, '0, '0,
                                                      '0, '0, sum_r, ok));
                        ph = ok ? ipd_pkg::PH_DONE : ipd_pkg::PH_HEADER;
                    end
                end
            end
        endcase
        pos_r = pkt_end ? 6'd0 : pos_r + 6'd1;
        if (step_results.size() != 0)
        begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        foreach (step_results[i])
            due_results.push_back(step_results[i]);
    endtask

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (act_v !== exp_v)
            note_fail($sformatf("%s expected %0h got %0h", what, exp_v, act_v));
    endtask

    // mostly short gaps, a few long ones, none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    function automatic logic [7:0] fill_byte(input int mode);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (mode == FILL_ONES)
            b = 8'hFF;
        else if (mode == FILL_ZEROS)
            b = 8'h00;
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        queued_cnt++;
    endtask

    // header, two colour packets and at least one data packet, up to the declared length
    task automatic queue_image(input logic [7:0] wide, input logic [7:0] tall,
                               input logic [15:0] len, input logic good,
                               input int mode);
        logic [7:0] data_q[$];
        logic [7:0] b;
        logic [7:0] sum;
        logic [7:0] skew;
        int npkt;
        npkt = 1;
        while (DATA_TALLY + PKT * npkt < int'(len))
            npkt++;
        sum = '0;
        for (int i = 0; i < npkt * PKT; i++)
        begin
            b = fill_byte(mode);
            data_q.push_back(b);
            sum = sum + b;
        end
        skew = 8'($urandom_range(1, 255));
        push_byte(ipd_pkg::MAGIC0);
        push_byte(ipd_pkg::MAGIC1);
        push_byte(wide);
        push_byte(tall);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(good ? sum : sum + skew);
        for (int i = ipd_pkg::POS_CHECK + 1; i < 3 * PKT; i++)
            push_byte(fill_byte(mode));
        foreach (data_q[i])
            push_byte(data_q[i]);
    endtask

    // header packet with broken magic
    task automatic queue_noise(input int variant);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        if (variant == BAD_SECOND)
        begin
            b0 = ipd_pkg::MAGIC0;
            while (b1 == ipd_pkg::MAGIC1)
                b1 = 8'($urandom_range(0, 255));
        end
        else if (variant == BAD_FIRST)
        begin
            b1 = ipd_pkg::MAGIC1;
            while (b0 == ipd_pkg::MAGIC0)
                b0 = 8'($urandom_range(0, 255));
        end
        else if (b0 == ipd_pkg::MAGIC0 && b1 == ipd_pkg::MAGIC1)
            b1 = ~ipd_pkg::MAGIC1;
        push_byte(b0);
        push_byte(b1);
        for (int i = 2; i < PKT; i++)
            push_byte(fill_byte(FILL_RANDOM));
    endtask

    // sender idle until every byte is in and every result has come
    task automatic wait_drained();
        int n;
        while (rx_backlog.size() != 0 || rx_valid)
            @(posedge clk);
        n = 0;
        while (due_results.size() != 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // calm stretches with no gaps on either side
    always @(posedge clk)
    begin
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end
        else
            calm_left <= calm_left - 1;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
            send_gap <= 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                deframe_byte(rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!rx_valid || rx_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    rx_valid <= 1'b0;
                end
                else if (rx_backlog.size() != 0)
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_backlog.pop_front();
                    send_gap <= pick_gap();
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // result monitor and result-side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                    note_fail($sformatf("unexpected result of kind %0d", kind));
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 24'(want.kind), 24'(kind));
                    check_field("img_wide", 24'(want.img_wide), 24'(img_wide));
                    check_field("img_tall", 24'(want.img_tall), 24'(img_tall));
                    check_field("colour_slot", 24'(want.colour_slot), 24'(colour_slot));
                    check_field("colour_rgb", want.colour_rgb, colour_rgb);
                    check_field("pixel_byte", 24'(want.pixel_byte), 24'(pixel_byte));
                    check_field("final_sum", 24'(want.final_sum), 24'(final_sum));
                    check_field("sum_ok", 24'(want.sum_ok), 24'(sum_ok));
                    check_field("last", 24'(want.last), 24'(last));
                end
            end
            if (sink_hold)
                res_ready <= 1'b0;
            else if (sink_gap != 0)
            begin
                sink_gap  <= sink_gap - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                sink_gap  <= pick_gap();
            end
        end
    end

    // long result-side hold while bytes keep coming, so the input backs up
    initial
    begin
        wait (bytes_taken >= 200);
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // stimulus and final verdict
    initial
    begin
        int r;
        int mode;
        logic [15:0] len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // broken magic on either byte, then the length corner cases
        queue_noise(BAD_SECOND);
        queue_noise(BAD_FIRST);
        queue_image(8'h00, 8'hFF, 16'd0, 1'b0, FILL_ZEROS);
        queue_image(8'hFF, 8'h00, 16'(DATA_TALLY), 1'b0, FILL_RANDOM);
        queue_image(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'(DATA_TALLY + 1), 1'b0, FILL_ONES);
        queue_image(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'(DATA_TALLY + PKT), 1'b0, FILL_ZEROS);
        wait_drained();

        // random image sequences with failing checksums, and broken headers
        while (queued_cnt < 560)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                queue_noise($urandom_range(BAD_SECOND, BAD_ANY));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = 16'($urandom_range(0, DATA_TALLY));
                else if (r < 85)
                    len = 16'($urandom_range(DATA_TALLY + 1, DATA_TALLY + 110));
                else
                    len = 16'($urandom_range(DATA_TALLY + 111, 400));
                r = $urandom_range(0, 19);
                mode = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
                queue_image(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            len, 1'b0, mode);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        // matching checksum locks the block; later bytes are swallowed
        queue_image(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(DATA_TALLY + 1, DATA_TALLY + 90)),
                    1'b1, FILL_RANDOM);
        push_byte(ipd_pkg::MAGIC0);
        push_byte(ipd_pkg::MAGIC1);
        for (int i = 0; i < 30; i++)
            push_byte(fill_byte(FILL_RANDOM));

        wait_drained();
        repeat (50) @(posedge clk);
        if (due_results.size() != 0)
            note_fail($sformatf("%0d results never delivered", due_results.size()));
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== image_packet_deframer.f =====
src/ipd_pkg.sv
src/ipd_core.sv
src/ipd_queue.sv
src/image_packet_deframer.sv
dv/tb_top.sv
